// File: src/klv_pkg.sv
// Package for the KLV triplet framer: action codes, BER limits and the
// encoder result type. No dependencies.
`default_nettype none

package klv_pkg;

    // Input transaction kinds.
    localparam logic [1:0] ACT_KEY = 2'd0;
    localparam logic [1:0] ACT_LEN = 2'd1;
    localparam logic [1:0] ACT_VAL = 2'd2;

    // BER short-form limit and long-form prefix marker.
    localparam logic [63:0] BER_SHORT_LIMIT = 64'd127;
    localparam logic [7:0]  BER_LONG_FLAG   = 8'h80;

    // Byte counts of the long forms.
    localparam logic [3:0] NB_1 = 4'd1;
    localparam logic [3:0] NB_2 = 4'd2;
    localparam logic [3:0] NB_4 = 4'd4;
    localparam logic [3:0] NB_8 = 4'd8;

    // Longest tail of bytes that follows the first output byte.
    localparam int TAIL_BYTES = 8;

    // What the encoder makes of one input transaction.
    typedef struct packed {
        logic        emit;        // transaction produces at least one byte
        logic [7:0]  first_byte;
        logic        first_last;
        logic        first_end;
        logic [63:0] tail;        // remaining bytes, left aligned, next one on top
        logic [3:0]  tail_cnt;    // number of remaining bytes, 0 to 8
    } t_enc;

endpackage

`default_nettype wire

// File: src/klv_ber_enc.sv
// Combinational encoder: turns one input transaction into its first output
// byte and a left-aligned tail of further BER length bytes. Uses klv_pkg.
`default_nettype none

module klv_ber_enc (
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [63:0] i_length_value,
    input  wire logic        i_final_value_byte,
    output klv_pkg::t_enc    o_enc
);

    logic [3:0] nbytes;

    // Pick the shortest long form that holds the length.
    always_comb begin
        priority if (i_length_value[63:8] == 56'd0) begin
            nbytes = klv_pkg::NB_1;
        end else if (i_length_value[63:16] == 48'd0) begin
            nbytes = klv_pkg::NB_2;
        end else if (i_length_value[63:32] == 32'd0) begin
            nbytes = klv_pkg::NB_4;
        end else begin
            nbytes = klv_pkg::NB_8;
        end
    end

    // Build the first byte and the tail for each transaction kind.
    always_comb begin
        o_enc = '0;
        unique case (i_action)
            klv_pkg::ACT_KEY: begin
                o_enc.emit       = 1'b1;
                o_enc.first_byte = i_data_byte;
                o_enc.first_last = 1'b1;
            end
            klv_pkg::ACT_VAL: begin
                o_enc.emit       = 1'b1;
                o_enc.first_byte = i_data_byte;
                o_enc.first_last = 1'b1;
                o_enc.first_end  = i_final_value_byte;
            end
            klv_pkg::ACT_LEN: begin
                o_enc.emit = 1'b1;
                if (i_length_value < klv_pkg::BER_SHORT_LIMIT) begin
                    // Short form: a zero length also closes the triplet.
                    o_enc.first_byte = i_length_value[7:0];
                    o_enc.first_last = 1'b1;
                    o_enc.first_end  = (i_length_value == 64'd0);
                end else begin
                    o_enc.first_byte = klv_pkg::BER_LONG_FLAG | {4'd0, nbytes};
                    o_enc.tail_cnt   = nbytes;
                    unique case (nbytes)
                        klv_pkg::NB_1: o_enc.tail = {i_length_value[7:0], 56'd0};
                        klv_pkg::NB_2: o_enc.tail = {i_length_value[15:0], 48'd0};
                        klv_pkg::NB_4: o_enc.tail = {i_length_value[31:0], 32'd0};
                        default:       o_enc.tail = i_length_value;
                    endcase
                end
            end
            default: begin
                // The unused action code produces no output.
                o_enc.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: src/klv_triplet_framer.sv
// KLV triplet framer: input register, BER encoder, tail shifter and output
// register. Uses klv_pkg and klv_ber_enc.
// A transaction in the input register goes through the BER encoder and its first byte
// is loaded into the output register. Throughput: one key or value byte per cycle while
// the output is not stalled; a long-form length stalls the input while the tail shifter drains.
// Reset (synchronous, active low) empties the input register, the tail and the output.
`default_nettype none

module klv_triplet_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [63:0] i_length_value,
    input  wire logic        i_final_value_byte,
    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_item,
    output logic             o_end_of_triplet
);

    // Input register.
    logic        r_in_valid;
    logic [1:0]  r_action;
    logic [7:0]  r_data_byte;
    logic [63:0] r_length_value;
    logic        r_final_value_byte;

    // Tail of a long-form length and the output register.
    logic [63:0] r_tail;
    logic [3:0]  r_tail_cnt;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_last;
    logic        r_end;

    klv_pkg::t_enc enc;
    logic          out_adv;
    logic          consume;
    logic          in_accept;

    klv_ber_enc u_enc (
        .i_action           (r_action),
        .i_data_byte        (r_data_byte),
        .i_length_value     (r_length_value),
        .i_final_value_byte (r_final_value_byte),
        .o_enc              (enc)
    );

    // The output register can load when it is empty or being taken.
    assign out_adv   = !r_out_valid || !i_out_stall;
    // The held transaction leaves once the tail is drained and its first
    // byte can move on; one with no output leaves at once.
    assign consume   = r_in_valid && (r_tail_cnt == 4'd0) && (out_adv || !enc.emit);
    assign o_in_stall = r_in_valid && !consume;
    assign in_accept = i_in_valid && !o_in_stall;

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (consume) begin
            r_in_valid <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_action           <= i_action;
            r_data_byte        <= i_data_byte;
            r_length_value     <= i_length_value;
            r_final_value_byte <= i_final_value_byte;
        end
    end

    // Tail count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_cnt  <= 4'd0;
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            if (r_tail_cnt != 4'd0) begin
                r_tail_cnt  <= r_tail_cnt - 4'd1;
                r_out_valid <= 1'b1;
            end else if (consume && enc.emit) begin
                r_tail_cnt  <= enc.tail_cnt;
                r_out_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Tail bytes and output byte payload.
    always_ff @(posedge i_clk) begin
        if (out_adv) begin
            if (r_tail_cnt != 4'd0) begin
                r_out_byte <= r_tail[63:56];
                r_last     <= (r_tail_cnt == 4'd1);
                r_end      <= 1'b0;
                r_tail     <= {r_tail[55:0], 8'd0};
            end else if (consume && enc.emit) begin
                r_out_byte <= enc.first_byte;
                r_last     <= enc.first_last;
                r_end      <= enc.first_end;
                r_tail     <= enc.tail;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_last_of_item   = r_last;
    assign o_end_of_triplet = r_end;

    // The tail never holds more than the longest long form.
    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tail_cnt <= 4'(klv_pkg::TAIL_BYTES))
        else $error("tail count beyond eight bytes");

    // A byte that closes the triplet is always the last of its transaction.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_end) |-> r_last)
        else $error("end of triplet on a byte that is not last");

    // A byte that is not last must have more bytes waiting in the tail.
    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_tail_cnt != 4'd0))
        else $error("non-final byte with an empty tail");

    // The tail does not move while the output is stalled.
    a_tail_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_tail_cnt != 4'd0) |=> $stable(r_tail_cnt))
        else $error("tail advanced under output stall");

endmodule

`default_nettype wire

// File: tb/klv_triplet_framer_test.sv
// Self-checking testbench for klv_triplet_framer: key, length and value transactions
// go in, and the serialized bytes are checked against a BER framing predictor.
// Depends on klv_pkg and the klv_triplet_framer RTL.
`default_nettype none

module klv_triplet_framer_test;

    timeunit 1ns;
    timeprecision 1ps;

    // The one action code that the package leaves unnamed; the block drops it.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Upper bounds of the one, two and four byte long forms.
    localparam logic [63:0] LIM_1 = 64'h0000_0000_0000_00FF;
    localparam logic [63:0] LIM_2 = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] LIM_4 = 64'h0000_0000_FFFF_FFFF;

    // Least number of random transactions that are not ignored by the block.
    localparam int RANDOM_ITEMS = 330;

    // One input transaction, plus a flag that holds it back until the output drains.
    typedef struct {
        logic [1:0]  act;
        logic [7:0]  data;
        logic [63:0] len;
        logic        fin;
        bit          drain;
    } t_item;

    // One serialized byte with its flags.
    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       eot;
    } t_frame_byte;

    logic        i_clk              = 1'b0;
    logic        i_rst_n            = 1'b0;
    logic        i_in_valid         = 1'b0;
    logic [1:0]  i_action           = klv_pkg::ACT_KEY;
    logic [7:0]  i_data_byte        = 8'h00;
    logic [63:0] i_length_value     = 64'd0;
    logic        i_final_value_byte = 1'b0;
    logic        i_out_stall        = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_last_of_item;
    logic        o_end_of_triplet;

    t_item       pending_items[$];
    t_frame_byte framed_bytes[$];
    t_item       cur_item;
    int          send_gap    = 0;
    int          stall_left  = 0;
    int          cycle_count = 0;
    int          fail_count  = 0;
    bit          calm;

    klv_triplet_framer dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_data_byte        (i_data_byte),
        .i_length_value     (i_length_value),
        .i_final_value_byte (i_final_value_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte         (o_out_byte),
        .o_last_of_item     (o_last_of_item),
        .o_end_of_triplet   (o_end_of_triplet)
    );

    // Clock, 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Reset is asserted at the start and never again.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stretches without any idling alternate with stretches of random gaps.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end
    assign calm = (cycle_count % 600) < 150;

    // Gap length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // Expected bytes of one transaction, appended to the framed byte store.
    task automatic frame_item(input t_item it);
        int nbytes;
        unique case (it.act)
            klv_pkg::ACT_KEY: framed_bytes.push_back('{it.data, 1'b1, 1'b0});
            klv_pkg::ACT_VAL: framed_bytes.push_back('{it.data, 1'b1, it.fin});
            klv_pkg::ACT_LEN: begin
                if (it.len < klv_pkg::BER_SHORT_LIMIT) begin
                    framed_bytes.push_back('{it.len[7:0], 1'b1, it.len == 64'd0});
                end else begin
                    if (it.len <= LIM_1)      nbytes = klv_pkg::NB_1;
                    else if (it.len <= LIM_2) nbytes = klv_pkg::NB_2;
                    else if (it.len <= LIM_4) nbytes = klv_pkg::NB_4;
                    else                      nbytes = klv_pkg::NB_8;
                    framed_bytes.push_back('{klv_pkg::BER_LONG_FLAG | 8'(nbytes),
                                             1'b0, 1'b0});
                    for (int i = nbytes - 1; i >= 0; i--) begin
                        framed_bytes.push_back('{8'(it.len >> (8 * i)), i == 0, 1'b0});
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    // Input driver: predicts each accepted transaction and presents the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) frame_item(cur_item);
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && framed_bytes.size() > 0)) begin
                    cur_item = pending_items.pop_front();
                    i_action           <= cur_item.act;
                    i_data_byte        <= cur_item.data;
                    i_length_value     <= cur_item.len;
                    i_final_value_byte <= cur_item.fin;
                    i_in_valid         <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: stalls at random and checks each accepted byte.
    always @(posedge i_clk) begin
        t_frame_byte want;
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            i_out_stall <= 1'b0;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (framed_bytes.size() == 0) begin
                report_mismatch("unexpected out_byte", o_out_byte, 'x);
            end else begin
                want = framed_bytes.pop_front();
                if (o_out_byte !== want.value)
                    report_mismatch("out_byte", o_out_byte, want.value);
                if (o_last_of_item !== want.last)
                    report_mismatch("last_of_item", 8'(o_last_of_item), 8'(want.last));
                if (o_end_of_triplet !== want.eot)
                    report_mismatch("end_of_triplet", 8'(o_end_of_triplet), 8'(want.eot));
            end
        end
    end

    task automatic add_item(input logic [1:0] act, input logic [7:0] data,
                            input logic [63:0] len, input logic fin, input bit drain);
        pending_items.push_back('{act, data, len, fin, drain});
    endtask

    function automatic logic [63:0] rand_wide();
        return {$urandom, $urandom} >> $urandom_range(0, 63);
    endfunction

    // Stimulus and end of run.
    initial begin
        int sent;
        int nkeys;
        int nvals;
        logic [63:0] len;

        // Directed: field extremes, every action, each BER boundary.
        add_item(klv_pkg::ACT_KEY, 8'h00, 64'd0, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_KEY, 8'hFF, '1, 1'b1, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'hFF, 64'd0, 1'b1, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, 64'd1, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'hA5, 64'd126, 1'b1, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h5A, 64'd127, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, 64'd128, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, LIM_1, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, LIM_1 + 1, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, LIM_2, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, LIM_2 + 1, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, LIM_4, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, LIM_4 + 1, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, '1, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_LEN, 8'h00, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_VAL, 8'h00, '1, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_VAL, 8'hFF, 64'd0, 1'b1, 1'b0);
        add_item(ACT_UNUSED, 8'hFF, '1, 1'b1, 1'b0);
        add_item(klv_pkg::ACT_VAL, 8'h3C, 64'd5, 1'b0, 1'b0);
        add_item(ACT_UNUSED, 8'h00, 64'd0, 1'b0, 1'b0);
        add_item(klv_pkg::ACT_VAL, 8'hC3, 64'd0, 1'b1, 1'b0);

        // Random: mostly well-formed triplets, the rest noise.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 8) begin
                nkeys = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 4);
                for (int k = 0; k < nkeys; k++) begin
                    add_item(klv_pkg::ACT_KEY, 8'($urandom), rand_wide(), 1'($urandom),
                             k == 0 && $urandom_range(0, 24) == 0);
                end
                len = ($urandom_range(0, 9) < 7) ? 64'($urandom_range(0, 12)) : rand_wide();
                add_item(klv_pkg::ACT_LEN, 8'($urandom), len, 1'($urandom), 1'b0);
                // Long lengths get a short broken value run with random closing flags.
                nvals = (len <= 64'd12) ? int'(len) : $urandom_range(1, 6);
                for (int v = 0; v < nvals; v++) begin
                    add_item(klv_pkg::ACT_VAL, 8'($urandom), rand_wide(),
                             (len <= 64'd12) ? (v == nvals - 1) : 1'($urandom), 1'b0);
                end
                sent += nkeys + 1 + nvals;
            end else begin
                len = rand_wide();
                add_item(2'($urandom), 8'($urandom), len, 1'($urandom), 1'b0);
                if (pending_items[$].act != ACT_UNUSED) sent++;
            end
        end
        // The sender waits for the output to drain at least once mid-run.
        pending_items[25].drain = 1'b1;

        while (pending_items.size() > 0 || i_in_valid) @(posedge i_clk);
        while (framed_bytes.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
